// ----- sv/mrc_pkg.sv -----
package mrc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_FRAME_BYTES = 256;
    localparam int DEF_MAX_REGISTERS   = 125;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int OUT_DATA_W = 40;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] EXC_FLAG_MASK = 8'h80;
    localparam int MIN_LEN_READ  = 5;
    localparam int MIN_LEN_WRITE = 8;
    localparam int HDR_TRAIL_LEN = 5;

    // Response modes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COUNT = 1'd1;

    // Result kinds
    localparam logic RES_REGISTER = 1'b0;
    localparam logic RES_STATUS   = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXCEPTION  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CRC_ERROR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT  = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              end_of_frame;
    } t_item;

    typedef struct packed {
        logic                result_type;
        logic [INDEX_W-1:0]  register_index;
        logic [VALUE_W-1:0]  register_value;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   exception_code;
        logic                frame_done;
    } t_result;

    // One byte through the reflected CRC, one bit per step
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/mrc_in_stage.sv -----
module mrc_in_stage
    import mrc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Take a new byte whenever the held one is empty or leaves this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/mrc_frame_check.sv -----
module mrc_frame_check
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int MAX_REGISTERS   = DEF_MAX_REGISTERS
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mode,
    input  logic [COUNT_W-1:0] i_expected_count,
    input  logic               i_valid,
    input  t_item              i_item,
    input  logic               i_advance,
    output logic               o_has_result,
    output t_result            o_result
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = (PW > 10) ? PW : 10;

    logic [15:0]       r_crc, n_crc;
    logic [PW-1:0]     r_pos, n_pos;
    logic [BYTE_W-1:0] r_d0, n_d0;
    logic [BYTE_W-1:0] r_d1, n_d1;
    logic              r_exc, n_exc;
    logic [BYTE_W-1:0] r_third, n_third;
    logic [BYTE_W-1:0] r_pending, n_pending;

    logic              in_range;
    logic [15:0]       crc_fed;
    logic [PW-1:0]     len;
    logic [CW-1:0]     len_w, third_w, k_w, min_len;
    logic [PW-1:0]     k;
    logic [15:0]       rx_crc;
    logic              reg_ok;

    always_comb begin
        in_range = r_pos < PW'(MAX_FRAME_BYTES);
        crc_fed  = (r_pos >= PW'(2)) ? crc_feed(r_crc, r_d0) : r_crc;
        len      = in_range ? r_pos + PW'(1) : r_pos;
        len_w    = CW'(len);

        n_crc     = crc_fed;
        n_pos     = len;
        n_d0      = r_d1;
        n_d1      = i_item.rx_byte;
        n_exc     = r_exc | ((r_pos == PW'(1)) && ((i_item.rx_byte & EXC_FLAG_MASK) != '0));
        n_third   = (r_pos == PW'(2)) ? i_item.rx_byte : r_third;
        n_pending = r_pending;

        third_w = CW'(n_third);
        rx_crc  = {i_item.rx_byte, r_d1};
        min_len = (i_mode == MODE_WRITE) ? CW'(MIN_LEN_WRITE) : CW'(MIN_LEN_READ);

        // Register number of the low byte at this position
        k      = (r_pos - PW'(4)) >> 1;
        k_w    = CW'(k);
        reg_ok = (k_w < CW'(i_expected_count)) && (k_w < CW'(MAX_REGISTERS))
                 && ((k_w << 1) + CW'(2) <= third_w);

        o_has_result = 1'b0;
        o_result     = '0;

        if (i_item.end_of_frame) begin
            o_has_result        = 1'b1;
            o_result.result_type = RES_STATUS;
            o_result.frame_done  = 1'b1;
            o_result.exception_code = n_exc ? n_third : '0;
            if (len_w < min_len) begin
                o_result.frame_status = ST_TOO_SHORT;
            end else if (n_exc) begin
                o_result.frame_status = ST_EXCEPTION;
            end else if (rx_crc != crc_fed) begin
                o_result.frame_status = ST_CRC_ERROR;
            end else if ((i_mode == MODE_READ) &&
                         ((len_w != third_w + CW'(HDR_TRAIL_LEN)) ||
                          (third_w < (CW'(i_expected_count) << 1)))) begin
                o_result.frame_status = ST_BAD_COUNT;
            end else begin
                o_result.frame_status = ST_OK;
            end
            // Drop all per-frame state
            n_crc     = CRC_INIT;
            n_pos     = '0;
            n_d0      = '0;
            n_d1      = '0;
            n_exc     = 1'b0;
            n_third   = '0;
            n_pending = '0;
        end else if ((i_mode == MODE_READ) && in_range && (r_pos >= PW'(3)) && !n_exc) begin
            if (r_pos[0]) begin
                n_pending = i_item.rx_byte;
            end else if (reg_ok) begin
                o_has_result            = 1'b1;
                o_result.result_type    = RES_REGISTER;
                o_result.register_index = k[INDEX_W-1:0];
                o_result.register_value = {r_pending, i_item.rx_byte};
            end
        end

        if (!i_valid) begin
            o_has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_INIT;
            r_pos     <= '0;
            r_d0      <= '0;
            r_d1      <= '0;
            r_exc     <= 1'b0;
            r_third   <= '0;
            r_pending <= '0;
        end else if (i_advance) begin
            r_crc     <= n_crc;
            r_pos     <= n_pos;
            r_d0      <= n_d0;
            r_d1      <= n_d1;
            r_exc     <= n_exc;
            r_third   <= n_third;
            r_pending <= n_pending;
        end
    end

endmodule

// ----- sv/mrc_out_stage.sv -----
module mrc_out_stage
    import mrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Slot is usable if empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- sv/modbus_rtu_response_checker_top.sv -----
// Modbus RTU response checker.
// Slave stream: one response byte per request on tdata, tlast on the final
// byte of the frame. Master stream: one result per request; tuser is the
// result kind (0 register value, 1 frame status), tlast marks the status
// result that closes the frame. Register results come out in read mode as
// each expected register completes; every frame ends with exactly one status.
// Config channel: index 0 sets the response mode (0 read, 1 write single),
// index 1 the expected register count; always ready, write while idle.
// Throughput: one byte per cycle unless a byte that gives a result waits for
// the result register; the CRC update is a single bytewise step between
// the input register and the result register. A byte is held in the input
// register, then its result in the result register.
// Reset (synchronous, active low) empties both registers, sets read mode, an
// expected count of 1 and CRC_INIT, and clears the rest of the frame state.
// Stall: a held result does not block bytes that give no result; a byte
// that gives a result waits in the input register until the result
// register is drained, and only then does the slave side back-pressure.
module modbus_rtu_response_checker_top
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int MAX_REGISTERS   = DEF_MAX_REGISTERS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] rx_byte
    input  logic                  i_s_axis_tlast,   // end_of_frame
    // Master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [6:0] register_index, [22:7] register_value, [25:23] frame_status,
    // [33:26] exception_code, [39:34] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser,   // result_type
    output logic                  o_m_axis_tlast,   // frame_done
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    logic               r_mode;
    logic [COUNT_W-1:0] r_expected_count;

    t_item   in_item, held_item;
    logic    held_valid;
    logic    has_result;
    t_result result, out_result;
    logic    out_free;
    logic    advance;

    // Configuration registers; the port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_READ;
            r_expected_count <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RESPONSE_MODE:  r_mode           <= i_cfg_data[0];
                CFG_EXPECTED_COUNT: r_expected_count <= i_cfg_data[COUNT_W-1:0];
                default:            r_mode           <= r_mode;
            endcase
        end
    end

    assign in_item.rx_byte      = i_s_axis_tdata;
    assign in_item.end_of_frame = i_s_axis_tlast;

    // Advance the held byte unless it yields a result with no room for it
    assign advance = held_valid && (!has_result || out_free);

    mrc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    mrc_frame_check #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MAX_REGISTERS   (MAX_REGISTERS)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (r_mode),
        .i_expected_count (r_expected_count),
        .i_valid          (held_valid),
        .i_item           (held_item),
        .i_advance        (advance),
        .o_has_result     (has_result),
        .o_result         (result)
    );

    mrc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (result),
        .i_ready  (i_m_axis_tready),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {6'd0,
                             out_result.exception_code,
                             out_result.frame_status,
                             out_result.register_value,
                             out_result.register_index};
    assign o_m_axis_tuser = out_result.result_type;
    assign o_m_axis_tlast = out_result.frame_done;

endmodule
